[rtl/assert_macros.svh]
// Assertion macros for the checker module of the blur block.
// No dependencies; take in with `include before any assertion is written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while the asynchronous reset is low.
`define BBG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define BBG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/bbg_pkg.sv]
// Shared types and constants of the 5x5 grey box blur.
// No dependencies; bbg_cell and the top level refer to it by scoped names.
`default_nettype none

package bbg_pkg;

	localparam int PIX_W     = 8;   // grey level bits
	localparam int FW_W      = 11;  // frame_width register bits
	localparam int FH_W      = 16;  // frame_height register bits
	localparam int CFG_W     = 16;  // widest register
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam int FRAME_WIDTH_RESET  = 640;
	localparam int FRAME_HEIGHT_RESET = 480;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// Per-cycle strobes handed to every window cell
	typedef struct packed {
		logic shift;     // take the neighbour's column
		logic load_sum;  // register the masked column sum
	} bbg_cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/bbg_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/bbg_cell.sv]
// One column of the blur window: holds WINDOW pixels, passes them on, and
// forms the masked column sum. Depends on bbg_pkg.
`default_nettype none

module bbg_cell #(
	parameter int WINDOW = 5,
	parameter int COL_W  = 11
) (
	input  logic                                clk,
	input  bbg_pkg::bbg_cell_ctrl_t             ctrl,
	input  logic [WINDOW*bbg_pkg::PIX_W-1:0]    col_in,    // lane 0 newest row
	output logic [WINDOW*bbg_pkg::PIX_W-1:0]    col_out,
	input  logic [WINDOW-1:0]                   row_mask,
	input  logic                                col_en,
	output logic [COL_W-1:0]                    col_sum
);

	localparam int PW = bbg_pkg::PIX_W;

	logic [WINDOW*PW-1:0] col_q;
	logic [COL_W-1:0]     col_sum_s3;
	logic [COL_W-1:0]     masked_sum;

	always_comb begin
		logic [COL_W-1:0] acc;
		acc = '0;
		for (int l = 0; l < WINDOW; l++) begin
			if (row_mask[l]) begin
				acc = acc + COL_W'(col_q[l*PW +: PW]);
			end
		end
		masked_sum = col_en ? acc : '0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			col_q <= col_in;
		end
		if (ctrl.load_sum) begin
			col_sum_s3 <= masked_sum;
		end
	end

	assign col_out = col_q;
	assign col_sum = col_sum_s3;

endmodule

`default_nettype wire

[rtl/box_blur_5x5_grey_unit.sv]
// Top level of the streaming grey box blur: counters, line store, cell
// chain, adder and scaling stages. Depends on bbg_pkg, bbg_ram, bbg_cell.
//
// Use: grey pixels enter in raster order on s_tdata with s_tuser low; after
// a frame's last pixel the producer sends drain items (s_tuser high), one
// per pending result. Each result is floor(window sum / WINDOW^2) of the
// zero-padded neighbourhood, raster order, on m_tdata; m_tlast marks the
// last result of a frame. Results lag input by WINDOW/2 rows plus WINDOW/2
// pixels. A drain item mid-frame is taken and dropped.
// Throughput: one item per clock unless a receiver stall or a small-frame
// flush holds s_tready low; set by the single line-store RAM access per item
// (read, then write-back of the shifted column when the item leaves stage 1).
// A result passes the window, column-sum, sum and product stages to the
// output register. Frames holding fewer pixels than the lag (WINDOW/2 * width
// + WINDOW/2) are shifted on up to the lag after the last pixel, s_tready low.
// Register writes (cfg_we) take effect at once and restart the frame.
// Reset only loads the default frame size and lag and clears counters and
// valid flags; the line store needs no clearing since edge masks hide stale data.
// Receiver stall: the output register holds; the stages behind it close
// up their bubbles, then s_tready drops.
`default_nettype none

module box_blur_5x5_grey_unit #(
	parameter int MAX_WIDTH = 1024,
	parameter int WINDOW    = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bbg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bbg_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] grey_in
	input  logic                              s_tuser,   // [0] kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // [7:0] grey_out
	output logic                              m_tlast
);

	localparam int PW      = bbg_pkg::PIX_W;
	localparam int HW      = bbg_pkg::FH_W;
	localparam int HALF    = WINDOW / 2;
	localparam int AW      = $clog2(MAX_WIDTH);
	localparam int WW      = $clog2(MAX_WIDTH + 1);
	localparam int CW      = WW + 1;
	localparam int LINES   = WINDOW - 1;
	localparam int LW      = LINES * PW;
	localparam int PIX_MAX = (2 ** PW) - 1;
	localparam int DIV     = WINDOW * WINDOW;
	localparam int COL_W   = $clog2(PIX_MAX * WINDOW + 1);
	localparam int SUM_W   = $clog2(PIX_MAX * DIV + 1);
	localparam int SHIFT   = SUM_W + $clog2(DIV);
	localparam int RECIP   = ((2 ** SHIFT) + DIV - 1) / DIV;
	localparam int PROD_W  = 2 * SUM_W + 2;
	localparam int LAG_W   = $clog2(HALF * MAX_WIDTH + HALF + 1);
	localparam int W_RESET = (bbg_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
	                         MAX_WIDTH : bbg_pkg::FRAME_WIDTH_RESET;

	function automatic logic [WW-1:0] sat_width(input logic [bbg_pkg::FW_W-1:0] v);
		logic [WW-1:0] r;
		if (v == '0) begin
			r = WW'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = WW'(MAX_WIDTH);
		end else begin
			r = WW'(v);
		end
		return r;
	endfunction

	function automatic logic [LAG_W-1:0] lag_of(input logic [WW-1:0] w);
		return LAG_W'(HALF * int'(w) + HALF);
	endfunction

	// frame geometry and position counters
	logic [WW-1:0]    w_q;
	logic [HW-1:0]    h_q;
	logic [AW-1:0]    in_col_q;
	logic [HW-1:0]    in_row_q;
	logic             in_done_q;
	logic [LAG_W-1:0] lag_cnt_q;
	logic [AW-1:0]    out_col_q;
	logic [HW-1:0]    out_row_q;

	// stage 1: item entered, line-store read in flight
	logic              v1_s1, emit_s1, last_s1;
	logic [PW-1:0]     pix_s1;
	logic [AW-1:0]     col_s1;
	logic [WINDOW-1:0] rmask_s1, cmask_s1;
	logic              fwd_q;
	logic [LW-1:0]     fwd_data_q;

	// stage 2: window in cells; stage 3: column sums in cells
	logic              v2_s2, last_s2;
	logic [WINDOW-1:0] rmask_s2, cmask_s2;
	logic              v3_s3, last_s3;
	logic              v4_s4, last_s4;
	logic [SUM_W-1:0]  sum_s4;
	logic              v5_s5, last_s5;
	logic [PROD_W-1:0] prod_s5;
	logic              out_valid_q, last_q;
	logic [PW-1:0]     grey_q;

	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;
	logic t12, t23, t34, t45, t5o;
	logic flush, acc, ignore, shift_in, emit_in;
	logic in_wrap, out_wrap, out_last, frame_done;
	logic [WINDOW-1:0] rmask, cmask;
	logic [LW-1:0]     ram_rdata, lines, new_line;
	logic [WINDOW*PW-1:0] column;
	logic [WW-1:0]     new_w;
	logic [HW-1:0]     new_h;
	logic [SUM_W-1:0]  win_sum;

	// pipeline handshake: each stage moves when the one ahead is free or moving
	assign rdy_o = !out_valid_q || m_tready;
	assign t5o   = v5_s5 && rdy_o;
	assign rdy5  = !v5_s5 || rdy_o;
	assign t45   = v4_s4 && rdy5;
	assign rdy4  = !v4_s4 || rdy5;
	assign t34   = v3_s3 && rdy4;
	assign rdy3  = !v3_s3 || rdy4;
	assign t23   = v2_s2 && rdy3;
	assign rdy2  = !v2_s2 || rdy3;
	assign t12   = v1_s1 && rdy2;
	assign rdy1  = !v1_s1 || rdy2;

	// small frames: shift the chain up to the lag before draining
	assign flush    = in_done_q && (lag_cnt_q != '0);
	assign s_tready = rdy1 && !flush;
	assign acc      = s_tvalid && s_tready;
	assign ignore   = (s_tuser == bbg_pkg::KIND_DRAIN) && !in_done_q;
	assign shift_in = (acc && !ignore) || (rdy1 && flush);
	assign emit_in  = shift_in && (lag_cnt_q == '0);

	assign in_wrap    = WW'(in_col_q) == (w_q - WW'(1));
	assign out_wrap   = WW'(out_col_q) == (w_q - WW'(1));
	assign out_last   = out_wrap && (out_row_q == (h_q - HW'(1)));
	assign frame_done = emit_in && out_last;

	assign new_w = sat_width(cfg_wdata[bbg_pkg::FW_W-1:0]);
	assign new_h = (cfg_wdata[HW-1:0] == '0) ? HW'(1) : cfg_wdata[HW-1:0];

	// edge masks of the window about to be formed, lane/cell g is offset HALF-g
	for (genvar g = 0; g < WINDOW; g++) begin : g_mask
		if (g <= HALF) begin : g_lo
			assign rmask[g] = ((HW+1)'(out_row_q) + (HW+1)'(HALF - g)) < (HW+1)'(h_q);
			assign cmask[g] = (CW'(out_col_q) + CW'(HALF - g)) < CW'(w_q);
		end else begin : g_hi
			assign rmask[g] = out_row_q >= HW'(g - HALF);
			assign cmask[g] = out_col_q >= AW'(g - HALF);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= WW'(W_RESET);
			h_q       <= HW'(bbg_pkg::FRAME_HEIGHT_RESET);
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			lag_cnt_q <= LAG_W'(HALF * W_RESET + HALF);
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bbg_pkg::REG_FRAME_WIDTH: begin
					w_q       <= new_w;
					lag_cnt_q <= lag_of(new_w);
					in_col_q  <= '0;
					in_row_q  <= '0;
					in_done_q <= 1'b0;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				bbg_pkg::REG_FRAME_HEIGHT: begin
					h_q       <= new_h;
					lag_cnt_q <= lag_of(w_q);
					in_col_q  <= '0;
					in_row_q  <= '0;
					in_done_q <= 1'b0;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (shift_in) begin
			if (frame_done) begin
				lag_cnt_q <= lag_of(w_q);
				in_col_q  <= '0;
				in_row_q  <= '0;
				in_done_q <= 1'b0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				// column keeps running after input ends so the chain stays aligned
				in_col_q <= in_wrap ? '0 : in_col_q + AW'(1);
				if (in_wrap && !in_done_q) begin
					if (in_row_q == (h_q - HW'(1))) begin
						in_done_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + HW'(1);
					end
				end
				if (lag_cnt_q != '0) begin
					lag_cnt_q <= lag_cnt_q - LAG_W'(1);
				end
				if (emit_in) begin
					out_col_q <= out_wrap ? '0 : out_col_q + AW'(1);
					if (out_wrap) begin
						out_row_q <= out_row_q + HW'(1);
					end
				end
			end
		end
	end

	// line store: one word per column, lane l delayed (l+1) rows
	assign lines    = fwd_q ? fwd_data_q : ram_rdata;
	assign column   = {lines, pix_s1};
	assign new_line = column[LW-1:0];

	bbg_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (t12),
		.waddr (col_s1),
		.wdata (new_line),
		.re    (shift_in),
		.raddr (in_col_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			fwd_q       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			v5_s5       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (shift_in) begin
				v1_s1 <= 1'b1;
				// same column written back this cycle: RAM read returns stale word
				fwd_q <= t12 && (col_s1 == in_col_q);
			end else if (t12) begin
				v1_s1 <= 1'b0;
			end
			if (t12) begin
				v2_s2 <= emit_s1;
			end else if (t23) begin
				v2_s2 <= 1'b0;
			end
			if (t23) begin
				v3_s3 <= 1'b1;
			end else if (t34) begin
				v3_s3 <= 1'b0;
			end
			if (t34) begin
				v4_s4 <= 1'b1;
			end else if (t45) begin
				v4_s4 <= 1'b0;
			end
			if (t45) begin
				v5_s5 <= 1'b1;
			end else if (t5o) begin
				v5_s5 <= 1'b0;
			end
			if (t5o) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_in) begin
			emit_s1    <= emit_in;
			last_s1    <= frame_done;
			pix_s1     <= s_tdata[PW-1:0];
			col_s1     <= in_col_q;
			rmask_s1   <= rmask;
			cmask_s1   <= cmask;
			fwd_data_q <= new_line;
		end
		if (t12) begin
			last_s2  <= last_s1;
			rmask_s2 <= rmask_s1;
			cmask_s2 <= cmask_s1;
		end
		if (t23) begin
			last_s3 <= last_s2;
		end
		if (t34) begin
			last_s4 <= last_s3;
			sum_s4  <= win_sum;
		end
		if (t45) begin
			last_s5 <= last_s4;
			prod_s5 <= PROD_W'(sum_s4) * PROD_W'(RECIP);
		end
		if (t5o) begin
			last_q <= last_s5;
			grey_q <= prod_s5[SHIFT +: PW];
		end
	end

	// cell chain: cell 0 holds the newest column
	bbg_pkg::bbg_cell_ctrl_t cell_ctrl;
	logic [WINDOW*PW-1:0]    chain   [WINDOW];
	logic [COL_W-1:0]        col_sum [WINDOW];

	assign cell_ctrl.shift    = t12;
	assign cell_ctrl.load_sum = t23;
	assign chain[0]           = column;

	for (genvar k = 0; k < WINDOW; k++) begin : g_cell
		if (k < WINDOW - 1) begin : g_mid
			bbg_cell #(
				.WINDOW (WINDOW),
				.COL_W  (COL_W)
			) u_cell (
				.clk      (clk),
				.ctrl     (cell_ctrl),
				.col_in   (chain[k]),
				.col_out  (chain[k+1]),
				.row_mask (rmask_s2),
				.col_en   (cmask_s2[k]),
				.col_sum  (col_sum[k])
			);
		end else begin : g_end
			bbg_cell #(
				.WINDOW (WINDOW),
				.COL_W  (COL_W)
			) u_cell (
				.clk      (clk),
				.ctrl     (cell_ctrl),
				.col_in   (chain[k]),
				.col_out  (),
				.row_mask (rmask_s2),
				.col_en   (cmask_s2[k]),
				.col_sum  (col_sum[k])
			);
		end
	end

	always_comb begin
		win_sum = '0;
		for (int k = 0; k < WINDOW; k++) begin
			win_sum = win_sum + SUM_W'(col_sum[k]);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = grey_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

[rtl/bbg_checker.sv]
// Port-level checks of the blur block, bound to the top level below.
// Depends on assert_macros.svh and box_blur_5x5_grey_unit.
`default_nettype none
`include "assert_macros.svh"

module bbg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// stalled result stays offered and unchanged
	`BBG_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`BBG_ASSERT(a_out_stable, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
	// reset empties the output register at once
	`BBG_ASSERT_ALWAYS(a_rst_empty, clk, !arst_n |-> !m_tvalid, "result offered in reset")
	// no result can come out faster than the five pipeline stages allow
	`BBG_ASSERT(a_lat_floor, clk, arst_n, m_tvalid |-> $past(arst_n, 5), "result too soon after reset")

endmodule

bind box_blur_5x5_grey_unit bbg_checker u_bbg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
